/* rtl/vector_norm_selectable_top_assert.svh */
// assertion macros for the vector norm block
// used by vector_norm_selectable_top, no other dependencies
`ifndef VECTOR_NORM_SELECTABLE_TOP_ASSERT_SVH
`define VECTOR_NORM_SELECTABLE_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define VNS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vns same-cycle check failed");

// next-cycle implication
`define VNS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vns next-cycle check failed");

`else

`define VNS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define VNS_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/vns_pkg.sv */
// shared constants and types for the vector norm block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package vns_pkg;

    localparam int MAX_LEN_DEF = 64;
    localparam int ELEM_W_DEF  = 24;

    // result field widths
    localparam int NORM_W      = 30;
    localparam int OUT_TDATA_W = 32;
    localparam logic [63:0] OUT_MAX = (64'd1 << NORM_W) - 64'd1;

    // accumulator widths and clamp levels
    localparam int SUM_W = 30;
    localparam logic [63:0] SUM_CAP = 64'd1 << 29;
    localparam int SQ_W  = 53;
    localparam logic [63:0] SQ_CAP = 64'd1 << 52;
    localparam int SQRT_W = 27;

    // norm kind codes
    localparam int KIND_W = 2;
    localparam logic [KIND_W-1:0] KIND_INF = 2'd0;
    localparam logic [KIND_W-1:0] KIND_L1  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_L2  = 2'd2;

    typedef struct packed {
        logic load;   // capture magnitude of a new element
        logic mul;    // square the held magnitude
        logic acc;    // fold into the running accumulators
        logic clr;    // clear accumulators after the result
    } t_acc_ctl;

endpackage

`default_nettype wire

/* rtl/vns_acc.sv */
// accumulator datapath: magnitude, shared squaring multiplier, running max/sum/sum of squares
// depends on vns_pkg
`timescale 1ns / 1ps
`default_nettype none

module vns_acc #(
    parameter int MAX_LEN = vns_pkg::MAX_LEN_DEF,
    parameter int EW      = vns_pkg::ELEM_W_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire vns_pkg::t_acc_ctl        i_ctl,
    input  wire logic signed [EW-1:0]     i_element,
    output logic [EW-1:0]                 o_largest,
    output logic [vns_pkg::SUM_W-1:0]     o_msum,
    output logic [vns_pkg::SQ_W-1:0]      o_ssum,
    output logic                          o_ovf
);

    localparam int CNT_W  = $clog2(MAX_LEN + 1);
    localparam int SUMT_W = ((EW > vns_pkg::SUM_W) ? EW : vns_pkg::SUM_W) + 1;
    localparam int SQT_W  = ((2 * EW > vns_pkg::SQ_W) ? 2 * EW : vns_pkg::SQ_W) + 1;

    logic [EW-1:0]             raw;
    logic [EW-1:0]             mag;
    logic [EW-1:0]             r_mag;
    logic [2*EW-1:0]           r_sq;
    logic [EW-1:0]             r_largest;
    logic [vns_pkg::SUM_W-1:0] r_msum;
    logic [vns_pkg::SQ_W-1:0]  r_ssum;
    logic [CNT_W-1:0]          r_cnt;
    logic                      r_ovf;
    logic [SUMT_W-1:0]         sum_tot;
    logic [SQT_W-1:0]          sq_tot;
    logic                      sum_clip;
    logic                      sq_clip;
    logic                      cnt_full;

    // most negative input maps to 2^(EW-1), still fits unsigned
    assign raw = i_element;
    assign mag = raw[EW-1] ? (~raw + 1'b1) : raw;

    assign sum_tot  = SUMT_W'(r_msum) + SUMT_W'(r_mag);
    assign sq_tot   = SQT_W'(r_ssum) + SQT_W'(r_sq);
    assign sum_clip = sum_tot > SUMT_W'(vns_pkg::SUM_CAP);
    assign sq_clip  = sq_tot > SQT_W'(vns_pkg::SQ_CAP);
    assign cnt_full = r_cnt >= CNT_W'(MAX_LEN);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_mag <= mag;
        end
        if (i_ctl.mul) begin
            r_sq <= r_mag * r_mag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clr) begin
            r_largest <= '0;
            r_msum    <= '0;
            r_ssum    <= '0;
            r_cnt     <= '0;
            r_ovf     <= 1'b0;
        end else if (i_ctl.acc) begin
            if (r_mag > r_largest) begin
                r_largest <= r_mag;
            end
            r_msum <= sum_clip ? vns_pkg::SUM_W'(vns_pkg::SUM_CAP)
                               : vns_pkg::SUM_W'(sum_tot);
            r_ssum <= sq_clip ? vns_pkg::SQ_W'(vns_pkg::SQ_CAP)
                              : vns_pkg::SQ_W'(sq_tot);
            if (!cnt_full) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (cnt_full || sum_clip || sq_clip) begin
                r_ovf <= 1'b1;
            end
        end
    end

    assign o_largest = r_largest;
    assign o_msum    = r_msum;
    assign o_ssum    = r_ssum;
    assign o_ovf     = r_ovf;

endmodule

`default_nettype wire

/* rtl/vns_sqrt.sv */
// iterative integer square root, two operand bits per cycle
// depends on vns_pkg
`timescale 1ns / 1ps
`default_nettype none

module vns_sqrt (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [vns_pkg::SQ_W-1:0]  i_operand,
    output logic                           o_done,
    output logic [vns_pkg::SQRT_W-1:0]     o_root
);

    localparam int W = vns_pkg::SQ_W;

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    t_state       r_state;
    logic [W-1:0] r_rem;
    logic [W-1:0] r_root;
    logic [W-1:0] r_bit;
    logic         r_done;
    logic [W:0]   trial;
    logic         fits;

    assign trial = {1'b0, r_root} + {1'b0, r_bit};
    assign fits  = {1'b0, r_rem} >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            // done pulses after the step on the lowest bit pair
            r_done <= (r_state == S_RUN) && r_bit[0];
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_rem   <= i_operand;
                        r_root  <= '0;
                        // highest even bit position of the operand
                        r_bit   <= W'(1) << (W - 1);
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (fits) begin
                        r_rem  <= r_rem - W'(trial);
                        r_root <= (r_root >> 1) + r_bit;
                    end else begin
                        r_root <= r_root >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_bit[0]) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_root = r_root[vns_pkg::SQRT_W-1:0];

endmodule

`default_nettype wire

/* rtl/vector_norm_selectable_top.sv */
// top level of the selectable vector norm: sequencer, config register, output register
// depends on vns_pkg, vns_acc, vns_sqrt and vector_norm_selectable_top_assert.svh
`timescale 1ns / 1ps
`default_nettype none
`include "vector_norm_selectable_top_assert.svh"

// usage
// - input stream: one signed q12.12 vector element per request on s_axis_tdata,
//   s_axis_tlast marks the final element of the vector
// - output stream: one request per vector, norm on m_axis_tdata (unsigned q18.12),
//   saturation flag on m_axis_tuser
// - i_cfg_wen/i_cfg_wdata write the norm kind (0 max magnitude, 1 sum of
//   magnitudes, 2 euclidean, 3 gives zero); write only while the block is idle
// - timing: each element is accepted, squared in the shared multiplier, then
//   accumulated; s_axis_tready stays low until that element is accumulated
// - after the last element: a finish state, in euclidean mode the 27 square
//   root steps at 2 bits per cycle and the done flag, then the load of the
//   output register once it is free
// - the output register is separate from the accumulators: while a result
//   waits, the elements of the next vector are still taken; only the next
//   vector's result waits for the receiver
// - reset (synchronous, active low) clears accumulators, drops m_axis_tvalid and
//   sets the norm kind to euclidean

module vector_norm_selectable_top #(
    parameter int MAX_LEN = vns_pkg::MAX_LEN_DEF,
    parameter int EW      = vns_pkg::ELEM_W_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // input stream
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    input  wire logic [((EW + 7) / 8) * 8 - 1:0]      s_axis_tdata,  // element[EW-1:0], zero pad
    input  wire logic                                 s_axis_tlast,
    // output stream
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    output logic [vns_pkg::OUT_TDATA_W-1:0]           m_axis_tdata,  // norm_value[29:0], zero pad
    output logic                                      m_axis_tuser,  // saturated[0]
    // configuration
    input  wire logic                                 i_cfg_wen,
    input  wire logic [vns_pkg::KIND_W-1:0]           i_cfg_wdata
);

    localparam int SEL_W = (EW > vns_pkg::NORM_W) ? EW : vns_pkg::NORM_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ACC,
        S_FIN,
        S_SQRT,
        S_OUT
    } t_state;

    t_state                         r_state;
    logic                           r_last;
    logic [vns_pkg::KIND_W-1:0]     r_kind;
    logic                           r_ovalid;
    logic [vns_pkg::NORM_W-1:0]     r_odata;
    logic                           r_osat;

    vns_pkg::t_acc_ctl              acc_ctl;
    logic [EW-1:0]                  largest;
    logic [vns_pkg::SUM_W-1:0]      msum;
    logic [vns_pkg::SQ_W-1:0]       ssum;
    logic                           ovf;
    logic                           sqrt_start;
    logic                           sqrt_done;
    logic [vns_pkg::SQRT_W-1:0]     root;

    logic                           in_req;
    logic                           out_load;
    logic [SEL_W-1:0]               largest_ext;
    logic [vns_pkg::NORM_W-1:0]     norm;
    logic                           norm_clip;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_req        = s_axis_tvalid && s_axis_tready;
    // output register free, or being emptied this cycle
    assign out_load      = (r_state == S_OUT) && (!r_ovalid || m_axis_tready);
    assign sqrt_start    = (r_state == S_FIN) && (r_kind == vns_pkg::KIND_L2);

    always_comb begin
        acc_ctl.load = in_req;
        acc_ctl.mul  = (r_state == S_MUL);
        acc_ctl.acc  = (r_state == S_ACC);
        acc_ctl.clr  = out_load;
    end

    vns_acc #(
        .MAX_LEN (MAX_LEN),
        .EW      (EW)
    ) u_acc (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (acc_ctl),
        .i_element ($signed(s_axis_tdata[EW-1:0])),
        .o_largest (largest),
        .o_msum    (msum),
        .o_ssum    (ssum),
        .o_ovf     (ovf)
    );

    vns_sqrt u_sqrt (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (sqrt_start),
        .i_operand (ssum),
        .o_done    (sqrt_done),
        .o_root    (root)
    );

    // norm selection; only the max magnitude can exceed the field for wide elements
    assign largest_ext = SEL_W'(largest);

    always_comb begin
        norm      = '0;
        norm_clip = 1'b0;
        unique case (r_kind)
            vns_pkg::KIND_INF: begin
                if (largest_ext > SEL_W'(vns_pkg::OUT_MAX)) begin
                    norm      = vns_pkg::NORM_W'(vns_pkg::OUT_MAX);
                    norm_clip = 1'b1;
                end else begin
                    norm = vns_pkg::NORM_W'(largest_ext);
                end
            end
            vns_pkg::KIND_L1: norm = msum;
            vns_pkg::KIND_L2: norm = vns_pkg::NORM_W'(root);
            default:          norm = '0;  // unused kind
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_kind   <= vns_pkg::KIND_L2;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_wen) begin
                r_kind <= i_cfg_wdata;
            end

            if (out_load) begin
                r_ovalid <= 1'b1;
                r_odata  <= norm;
                r_osat   <= ovf || norm_clip;
            end else if (r_ovalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_req) begin
                        r_last  <= s_axis_tlast;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: r_state <= S_ACC;
                S_ACC: r_state <= r_last ? S_FIN : S_IDLE;
                // accumulators settled, square sum ready for the root unit
                S_FIN: r_state <= sqrt_start ? S_SQRT : S_OUT;
                S_SQRT: begin
                    if (sqrt_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = vns_pkg::OUT_TDATA_W'(r_odata);
    assign m_axis_tuser  = r_osat;

    // a taken element keeps the block busy for the following cycle
    `VNS_ASSERT_NXT(a_busy_after_req, i_clk, i_rst_n, in_req, !s_axis_tready)
    // the root unit only finishes while the sequencer waits for it
    `VNS_ASSERT_IMP(a_sqrt_done_state, i_clk, i_rst_n, sqrt_done, r_state == S_SQRT)
    // a new result never overwrites one still waiting
    `VNS_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, out_load, !m_axis_tvalid || m_axis_tready)

endmodule

`default_nettype wire
